@@ hdl/pbd_pkg.sv @@
// Shared types and constants of the projection band detector.
// No dependencies; every other file imports this package.
package pbd_pkg;

  // Gray weights over 256 for blue, green and red.
  localparam logic [7:0] CoefBlue  = 8'd29;
  localparam logic [7:0] CoefGreen = 8'd150;
  localparam logic [7:0] CoefRed   = 8'd77;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    RegRoiLeft   = 3'd0,
    RegRoiRight  = 3'd1,
    RegRoiTop    = 3'd2,
    RegRoiBottom = 3'd3,
    RegMinHeight = 3'd4,
    RegMaxHeight = 3'd5,
    RegPitch     = 3'd6,
    RegPitchTol  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] roi_left;
    logic [11:0] roi_right;
    logic [10:0] roi_top;
    logic [10:0] roi_bottom;
    logic [10:0] min_band_height;
    logic [10:0] max_band_height;
    logic [9:0]  nominal_pitch;
    logic [7:0]  pitch_tolerance;
  } cfg_t;

endpackage

@@ hdl/pbd_cfg_regs.sv @@
// Configuration register file of the projection band detector.
// Depends on pbd_pkg for the register map and the cfg_t bundle.
module pbd_cfg_regs import pbd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roi_left        <= 12'd0;
      cfg_q.roi_right       <= 12'd2048;
      cfg_q.roi_top         <= 11'd0;
      cfg_q.roi_bottom      <= 11'd1024;
      cfg_q.min_band_height <= 11'd1;
      cfg_q.max_band_height <= 11'd1024;
      cfg_q.nominal_pitch   <= 10'd0;
      cfg_q.pitch_tolerance <= 8'd26;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegRoiLeft:   cfg_q.roi_left        <= cfg_data_i;
        RegRoiRight:  cfg_q.roi_right       <= cfg_data_i;
        RegRoiTop:    cfg_q.roi_top         <= cfg_data_i[10:0];
        RegRoiBottom: cfg_q.roi_bottom      <= cfg_data_i[10:0];
        RegMinHeight: cfg_q.min_band_height <= cfg_data_i[10:0];
        RegMaxHeight: cfg_q.max_band_height <= cfg_data_i[10:0];
        RegPitch:     cfg_q.nominal_pitch   <= cfg_data_i[9:0];
        RegPitchTol:  cfg_q.pitch_tolerance <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/pbd_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on pbd_pkg only by convention of the project.
module pbd_divider import pbd_pkg::*; #(
  parameter int DW = 32,
  parameter int VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dsr_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [VW:0]     shifted;
  logic [VW:0]     diff;
  logic            ge;

  assign shifted    = {rem_q, dvd_q[DW-1]};
  assign diff       = shifted - {1'b0, dsr_q};
  assign ge         = shifted >= {1'b0, dsr_q};
  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= CNTW'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[DW-2:0], ge};
        rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/pbd_pixel_accum.sv @@
// Gray conversion and per-row sum/count of the columns inside the ROI (all columns when roi_right >= MAX_COLUMNS).
// Depends on pbd_pkg for the gray weights and cfg_t.
module pbd_pixel_accum import pbd_pkg::*; #(
  parameter int MAX_COLUMNS = 2048
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        accept_i,
  input  logic                                        clear_i,
  input  cfg_t                                        cfg_i,
  input  logic [7:0]                                  blue_i,
  input  logic [7:0]                                  green_i,
  input  logic [7:0]                                  red_i,
  output logic [$clog2(255*MAX_COLUMNS+1)-1:0]        sum_o,
  output logic [$clog2(MAX_COLUMNS+1)-1:0]            count_o
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int SW = $clog2(255 * MAX_COLUMNS + 1);

  logic [CW-1:0] col_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] sum_q;
  logic [15:0]   gray_sum;
  logic [7:0]    gray;
  logic          use_roi;
  logic          in_cols;
  logic          col_ok;

  assign gray_sum = 16'(blue_i) * 16'(CoefBlue) + 16'(green_i) * 16'(CoefGreen)
                  + 16'(red_i) * 16'(CoefRed);
  assign gray     = gray_sum[15:8];
  assign use_roi  = 32'(cfg_i.roi_right) < MAX_COLUMNS;
  assign col_ok   = 32'(col_q) < MAX_COLUMNS;
  assign in_cols  = !use_roi || ((32'(col_q) >= 32'(cfg_i.roi_left)) &&
                                 (32'(col_q) < 32'(cfg_i.roi_right)));
  assign sum_o    = sum_q;
  assign count_o  = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else if (clear_i) begin
      col_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
    end else if (accept_i && col_ok) begin
      // drop pixels past the last column
      col_q <= col_q + 1'b1;
      if (in_cols) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + SW'(gray);
      end
    end
  end

endmodule

@@ hdl/projection_band_detector_top.sv @@
// Projection band detector top: pixel intake, row projection store, band scan,
// pitch filter and result sequencer. Uses pbd_pkg, pbd_cfg_regs,
// pbd_divider and pbd_pixel_accum.
//
// Flow: a plain pixel leaves busy low. A row end holds busy through S_ROW,
// the row-mean divide on the shared bit-per-cycle divider (DIVW = 32 at
// the default size), S_ROWWR and S_ROWEND; a row outside the region or with
// no pixels in it skips the divide. A frame end then adds, per stored row, a
// projection memory read, a shared multiplier step and a compare; per band,
// the read and check states of the two pitch filter passes; and per emitted
// band, a band memory read and the confidence divide.
// Results come as one-cycle strobes; the receiver cannot stall them.
// Reset is asynchronous, active low; it clears all control state. No
// memory is cleared: every entry is written in a frame before it is read.
module projection_band_detector_top import pbd_pkg::*; #(
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_BANDS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel words
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          red_i,
  input  logic                end_of_row_i,
  input  logic                end_of_frame_i,
  // configuration words
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // result words
  output logic                result_valid_o,
  output logic                band_found_o,
  output logic [9:0]          band_top_o,
  output logic [9:0]          band_bottom_o,
  output logic [9:0]          band_center_o,
  output logic [15:0]         confidence_o,
  output logic                overflow_o,
  output logic                last_o
);

  localparam int CW   = $clog2(MAX_COLUMNS + 1);
  localparam int SW   = $clog2(255 * MAX_COLUMNS + 1);
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int RIW  = $clog2(MAX_ROWS);
  localparam int TW   = $clog2(65280 * MAX_ROWS + 1);
  localparam int DIVW = (SW + 8 > 32) ? SW + 8 : 32;
  localparam int BAW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int BCW  = $clog2(MAX_BANDS + 1);
  localparam int BEW  = 2 * RIW + 16;
  localparam int CMPW = ((TW > 32) ? TW : 32) + 2;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001, S_ROW   = 23'h000002, S_ROWDIV = 23'h000004,
    S_ROWWR = 23'h000008, S_ROWEND = 23'h000010, S_RHS   = 23'h000020,
    S_LO    = 23'h000040, S_HI    = 23'h000080, S_SINIT  = 23'h000100,
    S_SRD   = 23'h000200, S_SMUL  = 23'h000400, S_SCMP   = 23'h000800,
    S_SEND  = 23'h001000, S_FILT  = 23'h002000, S_F1RD   = 23'h004000,
    S_F1CK  = 23'h008000, S_F2RD  = 23'h010000, S_F2CK   = 23'h020000,
    S_EINIT = 23'h040000, S_ERD   = 23'h080000, S_EDIV   = 23'h100000,
    S_EWAIT = 23'h200000, S_EOUT  = 23'h400000
  } state_e;

  state_e state_q;

  cfg_t cfg;

  pbd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // pixel intake
  logic          accept;
  logic          acc_clear;
  logic [SW-1:0] row_sum;
  logic [CW-1:0] row_cnt;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  pbd_pixel_accum #(.MAX_COLUMNS(MAX_COLUMNS)) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .clear_i  (acc_clear),
    .cfg_i    (cfg),
    .blue_i   (blue_i),
    .green_i  (green_i),
    .red_i    (red_i),
    .sum_o    (row_sum),
    .count_o  (row_cnt)
  );

  // shared divider: row mean and band confidence
  logic            div_start;
  logic [DIVW-1:0] div_dividend;
  logic [15:0]     div_divisor;
  logic            div_done;
  logic [DIVW-1:0] div_quot;

  pbd_divider #(.DW(DIVW), .VW(16)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // frame state
  logic          eof_q;
  logic [RW-1:0] row_idx_q;
  logic [TW-1:0] total_q;
  logic [15:0]   peak_q;
  logic [15:0]   v_q;

  // shared multiplier, registered product
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] prod_q;

  // scan state
  logic [CMPW-1:0] rhs_q;
  logic [31:0]     lo_q;
  logic [31:0]     hi_q;
  logic [RW-1:0]   y_q;
  logic            in_run_q;
  logic [RIW-1:0]  run_top_q;
  logic [15:0]     run_pk_q;
  logic [15:0]     p_q;

  // band store state
  logic [BCW-1:0] band_cnt_q;
  logic           ovf_q;
  logic [BCW-1:0] i_q;
  logic [BCW-1:0] kept_q;
  logic [RIW-1:0] last_c_q;

  // projection memory
  logic [15:0] proj_mem [MAX_ROWS];
  logic [15:0] proj_rd_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_ROWWR) begin
      proj_mem[row_idx_q[RIW-1:0]] <= v_q;
    end
    if (state_q == S_SRD) begin
      proj_rd_q <= proj_mem[y_q[RIW-1:0]];
    end
  end

  // band memory: {top, bottom, peak}
  logic [BEW-1:0] band_mem [MAX_BANDS];
  logic [BEW-1:0] band_rd_q;
  logic           bw_en;
  logic [BAW-1:0] bw_addr;
  logic [BEW-1:0] bw_data;
  logic           br_en;

  assign br_en = (state_q == S_F1RD) || (state_q == S_F2RD) || (state_q == S_ERD);

  always_ff @(posedge clk_i) begin
    if (bw_en) begin
      band_mem[bw_addr] <= bw_data;
    end
    if (br_en) begin
      band_rd_q <= band_mem[i_q[BAW-1:0]];
    end
  end

  // fields of the band just read
  logic [RIW-1:0] rd_top;
  logic [RIW-1:0] rd_bot;
  logic [15:0]    rd_pk;
  logic [31:0]    rd_csum;
  logic [RIW-1:0] rd_center;
  logic [RIW-1:0] d_first;
  logic           ok_first;
  logic           ok_kept;

  assign rd_top    = band_rd_q[BEW-1 -: RIW];
  assign rd_bot    = band_rd_q[RIW+15 -: RIW];
  assign rd_pk     = band_rd_q[15:0];
  assign rd_csum   = 32'(rd_top) + 32'(rd_bot);
  assign rd_center = rd_csum[RIW:1];
  assign d_first   = rd_center - last_c_q;
  assign ok_first  = ({24'd0, d_first, 8'd0} >= {{(RIW){1'b0}}, lo_q}) &&
                     ({24'd0, d_first, 8'd0} <= {{(RIW){1'b0}}, hi_q});
  assign ok_kept   = ok_first;

  // threshold compare: 2*H*p > T + H*M
  logic above;
  assign above = {CMPW'(prod_q), 1'b0} > {1'b0, rhs_q};

  // band close request from the scan
  logic           add_req;
  logic [RIW-1:0] add_bot;
  logic [31:0]    add_h;
  logic           add_fit;
  logic [RW-1:0]  y_m1;

  assign y_m1    = y_q - 1'b1;
  assign add_req = ((state_q == S_SCMP) && !above && in_run_q) ||
                   ((state_q == S_SEND) && in_run_q);
  assign add_bot = y_m1[RIW-1:0];
  assign add_h   = 32'(add_bot) - 32'(run_top_q) + 32'd1;
  assign add_fit = (add_h >= 32'(cfg.min_band_height)) &&
                   (add_h <= 32'(cfg.max_band_height));

  // band write port: scan appends, filter compacts
  always_comb begin
    bw_en   = 1'b0;
    bw_addr = band_cnt_q[BAW-1:0];
    bw_data = {run_top_q, add_bot, run_pk_q};
    if (add_req && add_fit && (32'(band_cnt_q) < MAX_BANDS)) begin
      bw_en = 1'b1;
    end else if ((state_q == S_F2CK) && ((kept_q == '0) || ok_kept)) begin
      bw_en   = 1'b1;
      bw_addr = kept_q[BAW-1:0];
      bw_data = band_rd_q;
    end
  end

  // row projection control
  logic row_in_roi;
  logic use_roi;
  assign use_roi    = 32'(cfg.roi_right) < MAX_COLUMNS;
  assign row_in_roi = !use_roi || ((32'(row_idx_q) >= 32'(cfg.roi_top)) &&
                                   (32'(row_idx_q) < 32'(cfg.roi_bottom)));
  assign acc_clear  = (state_q == S_ROWEND);

  // multiplier operand select
  always_comb begin
    mul_a = 16'(row_idx_q);
    mul_b = peak_q;
    unique case (state_q)
      S_LO: begin
        mul_a = 16'(cfg.nominal_pitch);
        mul_b = 16'd256 - 16'(cfg.pitch_tolerance);
      end
      S_HI: begin
        mul_a = 16'(cfg.nominal_pitch);
        mul_b = 16'd256 + 16'(cfg.pitch_tolerance);
      end
      S_SMUL: mul_b = proj_rd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 32'(mul_a) * 32'(mul_b);
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIVW'({row_sum, 8'd0});
    div_divisor  = 16'(row_cnt);
    if ((state_q == S_ROW) && (32'(row_idx_q) < MAX_ROWS) && row_in_roi &&
        (row_cnt != '0)) begin
      div_start = 1'b1;
    end else if ((state_q == S_EDIV) && (peak_q != 16'd0)) begin
      div_start    = 1'b1;
      div_dividend = DIVW'({rd_pk, 16'd0});
      div_divisor  = peak_q;
    end
  end

  // emission payload
  logic [15:0] conf_q;
  logic [BEW-1:0] cur_q;
  logic [31:0] cur_top32;
  logic [31:0] cur_bot32;
  logic [31:0] cur_c32;
  logic        is_last;

  assign cur_top32 = 32'(cur_q[BEW-1 -: RIW]);
  assign cur_bot32 = 32'(cur_q[RIW+15 -: RIW]);
  assign cur_c32   = (cur_top32 + cur_bot32) >> 1;
  assign is_last   = (i_q + 1'b1) == band_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      eof_q          <= 1'b0;
      row_idx_q      <= '0;
      total_q        <= '0;
      peak_q         <= '0;
      v_q            <= '0;
      rhs_q          <= '0;
      lo_q           <= '0;
      hi_q           <= '0;
      y_q            <= '0;
      in_run_q       <= 1'b0;
      run_top_q      <= '0;
      run_pk_q       <= '0;
      p_q            <= '0;
      band_cnt_q     <= '0;
      ovf_q          <= 1'b0;
      i_q            <= '0;
      kept_q         <= '0;
      last_c_q       <= '0;
      conf_q         <= '0;
      cur_q          <= '0;
      result_valid_o <= 1'b0;
      band_found_o   <= 1'b0;
      band_top_o     <= '0;
      band_bottom_o  <= '0;
      band_center_o  <= '0;
      confidence_o   <= '0;
      overflow_o     <= 1'b0;
      last_o         <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && (end_of_row_i || end_of_frame_i)) begin
            eof_q   <= end_of_frame_i;
            state_q <= S_ROW;
          end
        end
        S_ROW: begin
          v_q <= '0;
          if (32'(row_idx_q) >= MAX_ROWS) begin
            state_q <= S_ROWEND;   // drop rows past the last one
          end else if (div_start) begin
            state_q <= S_ROWDIV;
          end else begin
            state_q <= S_ROWWR;
          end
        end
        S_ROWDIV: begin
          if (div_done) begin
            v_q     <= div_quot[15:0];
            state_q <= S_ROWWR;
          end
        end
        S_ROWWR: begin
          total_q   <= total_q + TW'(v_q);
          if (v_q > peak_q) begin
            peak_q <= v_q;
          end
          row_idx_q <= row_idx_q + 1'b1;
          state_q   <= S_ROWEND;
        end
        S_ROWEND: begin
          state_q <= eof_q ? S_RHS : S_IDLE;
        end
        S_RHS: state_q <= S_LO;
        S_LO: begin
          rhs_q   <= CMPW'(total_q) + CMPW'(prod_q);
          state_q <= S_HI;
        end
        S_HI: begin
          lo_q    <= prod_q;
          state_q <= S_SINIT;
        end
        S_SINIT: begin
          hi_q       <= prod_q;
          y_q        <= '0;
          in_run_q   <= 1'b0;
          band_cnt_q <= '0;
          ovf_q      <= 1'b0;
          state_q    <= S_SRD;
        end
        S_SRD: begin
          state_q <= (y_q == row_idx_q) ? S_SEND : S_SMUL;
        end
        S_SMUL: begin
          p_q     <= proj_rd_q;
          state_q <= S_SCMP;
        end
        S_SCMP: begin
          if (above && !in_run_q) begin
            in_run_q  <= 1'b1;
            run_top_q <= y_q[RIW-1:0];
            run_pk_q  <= p_q;
          end else if (above) begin
            if (p_q > run_pk_q) begin
              run_pk_q <= p_q;
            end
          end else if (in_run_q) begin
            in_run_q <= 1'b0;
          end
          y_q     <= y_q + 1'b1;
          state_q <= S_SRD;
        end
        S_SEND: begin
          in_run_q <= 1'b0;
          state_q  <= S_FILT;
        end
        S_FILT: begin
          i_q <= '0;
          if ((cfg.nominal_pitch == 10'd0) || (band_cnt_q < BCW'(2))) begin
            state_q <= S_EINIT;
          end else begin
            state_q <= S_F1RD;
          end
        end
        S_F1RD: begin
          if (i_q == band_cnt_q) begin
            band_cnt_q <= BCW'(1);   // no pair in pitch: keep the first band
            state_q    <= S_EINIT;
          end else begin
            state_q <= S_F1CK;
          end
        end
        S_F1CK: begin
          if ((i_q != '0) && ok_first) begin
            i_q     <= i_q - 1'b1;
            kept_q  <= '0;
            state_q <= S_F2RD;
          end else begin
            last_c_q <= rd_center;
            i_q      <= i_q + 1'b1;
            state_q  <= S_F1RD;
          end
        end
        S_F2RD: begin
          if (i_q == band_cnt_q) begin
            band_cnt_q <= kept_q;
            state_q    <= S_EINIT;
          end else begin
            state_q <= S_F2CK;
          end
        end
        S_F2CK: begin
          if ((kept_q == '0) || ok_kept) begin
            kept_q   <= kept_q + 1'b1;
            last_c_q <= rd_center;
          end
          i_q     <= i_q + 1'b1;
          state_q <= S_F2RD;
        end
        S_EINIT: begin
          i_q <= '0;
          if (band_cnt_q == '0) begin
            // empty frame: one result with no band
            result_valid_o <= 1'b1;
            band_found_o   <= 1'b0;
            band_top_o     <= '0;
            band_bottom_o  <= '0;
            band_center_o  <= '0;
            confidence_o   <= '0;
            overflow_o     <= ovf_q;
            last_o         <= 1'b1;
            row_idx_q      <= '0;
            total_q        <= '0;
            peak_q         <= '0;
            state_q        <= S_IDLE;
          end else begin
            state_q <= S_ERD;
          end
        end
        S_ERD: state_q <= S_EDIV;
        S_EDIV: begin
          cur_q <= band_rd_q;
          if (peak_q == 16'd0) begin
            conf_q  <= '0;
            state_q <= S_EOUT;
          end else begin
            state_q <= S_EWAIT;
          end
        end
        S_EWAIT: begin
          if (div_done) begin
            conf_q  <= (div_quot > DIVW'(65535)) ? 16'hFFFF : div_quot[15:0];
            state_q <= S_EOUT;
          end
        end
        S_EOUT: begin
          result_valid_o <= 1'b1;
          band_found_o   <= 1'b1;
          band_top_o     <= cur_top32[9:0];
          band_bottom_o  <= cur_bot32[9:0];
          band_center_o  <= cur_c32[9:0];
          confidence_o   <= conf_q;
          overflow_o     <= ovf_q;
          last_o         <= is_last;
          if (is_last) begin
            row_idx_q <= '0;
            total_q   <= '0;
            peak_q    <= '0;
            state_q   <= S_IDLE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_ERD;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // append a closed run; count past capacity only as overflow
      if (add_req && add_fit) begin
        if (32'(band_cnt_q) >= MAX_BANDS) begin
          ovf_q <= 1'b1;
        end else begin
          band_cnt_q <= band_cnt_q + 1'b1;
        end
      end
    end
  end

endmodule
